// ===== rtl/bfs_pkg.sv =====
// Shared types, opcodes and constants for the bit-field swizzle ALU.
// No dependencies; used by bfs_field_unit and bit_field_swizzle_alu.
`default_nettype none

package bfs_pkg;

    // Field widths
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned START_W   = 6;
    localparam int unsigned LEN_W     = 7;
    localparam int unsigned OPND_W    = 32;
    localparam int unsigned SUM_W     = 8;

    // Stream packing
    localparam int unsigned IN_DATA_W  = 112;
    localparam int unsigned OUT_DATA_W = 64;

    // Highest bit position (exclusive) a rotated field may reach
    localparam int unsigned ROTATE_LIMIT = 48;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ROR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ROL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SUB  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_XOR  = 3'd5;

    // One input item as held in the input register
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] load_value;
        logic [START_W-1:0] field_start;
        logic [LEN_W-1:0]   field_length;
        logic [OPND_W-1:0]  operand;
        logic               last_op;
    } t_req;

    // Outcome of one operation on the working value
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               range_error;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/bfs_field_unit.sv =====
// Combinational field operation: applies one request to the working value.
// Depends on bfs_pkg for the request and result types and the opcodes.
`default_nettype none

module bfs_field_unit (
    input  wire bfs_pkg::t_req              i_req,
    input  wire [bfs_pkg::VALUE_W-1:0]      i_work,
    output bfs_pkg::t_res                   o_res
);

    logic                          is_rot;
    logic                          is_arith;
    logic                          short_rot;
    logic [bfs_pkg::SUM_W-1:0]     field_end;
    logic                          err;
    logic [bfs_pkg::VALUE_W-1:0]   mask;
    logic [bfs_pkg::VALUE_W-1:0]   field;
    logic [bfs_pkg::VALUE_W-1:0]   new_field;
    logic [bfs_pkg::LEN_W-1:0]     top_pos;
    logic                          top_bit;
    logic [bfs_pkg::VALUE_W-1:0]   opnd_ext;
    logic [bfs_pkg::VALUE_W-1:0]   merged;

    // Decode the request class
    always_comb begin
        is_rot   = (i_req.req_type == bfs_pkg::REQ_ROR) || (i_req.req_type == bfs_pkg::REQ_ROL);
        is_arith = (i_req.req_type == bfs_pkg::REQ_ADD) || (i_req.req_type == bfs_pkg::REQ_SUB)
                || (i_req.req_type == bfs_pkg::REQ_XOR);
        short_rot = is_rot && (i_req.field_length <= bfs_pkg::LEN_W'(1));
    end

    // Range checks: field past the top bit, or a rotate passing the limit
    always_comb begin
        field_end = bfs_pkg::SUM_W'(i_req.field_start) + bfs_pkg::SUM_W'(i_req.field_length);
        err = (is_rot || is_arith) && !short_rot
           && ((field_end > bfs_pkg::SUM_W'(bfs_pkg::VALUE_W))
            || (is_rot && (field_end >= bfs_pkg::SUM_W'(bfs_pkg::ROTATE_LIMIT + 1))));
    end

    // Extract the field down to bit zero
    always_comb begin
        if (i_req.field_length >= bfs_pkg::LEN_W'(bfs_pkg::VALUE_W)) begin
            mask = '1;
        end else begin
            mask = (bfs_pkg::VALUE_W'(1) << i_req.field_length[bfs_pkg::START_W-1:0])
                 - bfs_pkg::VALUE_W'(1);
        end
        field    = (i_work >> i_req.field_start) & mask;
        top_pos  = i_req.field_length - bfs_pkg::LEN_W'(1);
        top_bit  = field[top_pos[bfs_pkg::START_W-1:0]];
        opnd_ext = bfs_pkg::VALUE_W'(i_req.operand);
    end

    // Compute the new field contents
    always_comb begin
        case (i_req.req_type)
            bfs_pkg::REQ_ROR: begin
                new_field = (field >> 1)
                          | (bfs_pkg::VALUE_W'(field[0]) << top_pos[bfs_pkg::START_W-1:0]);
            end
            bfs_pkg::REQ_ROL: begin
                new_field = (field << 1) | bfs_pkg::VALUE_W'(top_bit);
            end
            bfs_pkg::REQ_ADD: begin
                new_field = field + opnd_ext;
            end
            bfs_pkg::REQ_SUB: begin
                new_field = field - opnd_ext;
            end
            bfs_pkg::REQ_XOR: begin
                new_field = field ^ opnd_ext;
            end
            default: begin
                new_field = field;
            end
        endcase
        merged = (i_work & ~(mask << i_req.field_start))
               | ((new_field & mask) << i_req.field_start);
    end

    // Select the resulting working value
    always_comb begin
        o_res.range_error = err;
        if (i_req.req_type == bfs_pkg::REQ_LOAD) begin
            o_res.value = i_req.load_value;
        end else if ((is_rot || is_arith) && !short_rot && !err) begin
            o_res.value = merged;
        end else begin
            o_res.value = i_work;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bit_field_swizzle_alu.sv =====
// Top level of the bit-field swizzle ALU: input register, working value,
// result register. Depends on bfs_pkg and bfs_field_unit.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | tdata: load_value, field_start, field_length,
//           |           |   operand; tuser: req_type; tlast: last_op
//  m_axis   | out       | tdata: value; tuser: range_error; tlast: done_res
//
// One item per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register, before it
// is offered. The working value updates in the same cycle its result
// is registered, so back-to-back items chain through it. Reset clears the
// working value to zero and empties both registers. A stalled output holds
// the result; the input register keeps accepting until it too is full.
`default_nettype none

module bit_field_swizzle_alu (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [63:0] load_value, [69:64] field_start, [76:70] field_length,
    // [108:77] operand, [111:109] unused
    input  wire [bfs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [2:0] req_type
    input  wire [bfs_pkg::REQ_W-1:0]          i_s_axis_tuser,
    input  wire                               i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // [63:0] value
    output logic [bfs_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [0] range_error
    output logic [0:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    bfs_pkg::t_req                 r_in;
    bfs_pkg::t_req                 n_in;
    logic                          r_in_valid;
    logic [bfs_pkg::VALUE_W-1:0]   r_work;
    logic                          r_out_valid;
    logic [bfs_pkg::VALUE_W-1:0]   r_out_value;
    logic                          r_out_err;
    logic                          r_out_last;
    bfs_pkg::t_res                 unit_res;
    logic                          in_xfer;
    logic                          advance;

    // Handshake: advance when the result register is free or draining
    always_comb begin
        advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
        o_s_axis_tready = !r_in_valid || advance;
        in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    end

    // Unpack the incoming transfer
    always_comb begin
        n_in.req_type     = i_s_axis_tuser;
        n_in.load_value   = i_s_axis_tdata[63:0];
        n_in.field_start  = i_s_axis_tdata[69:64];
        n_in.field_length = i_s_axis_tdata[76:70];
        n_in.operand      = i_s_axis_tdata[108:77];
        n_in.last_op      = i_s_axis_tlast;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_xfer) begin
            r_in <= n_in;
        end
    end

    bfs_field_unit u_field (
        .i_req  (r_in),
        .i_work (r_work),
        .o_res  (unit_res)
    );

    // Working value and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_work      <= unit_res.value;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_value <= unit_res.value;
            r_out_err   <= unit_res.range_error;
            r_out_last  <= r_in.last_op;
        end
    end

    // Drive the result channel
    always_comb begin
        o_m_axis_tvalid   = r_out_valid;
        o_m_axis_tdata    = r_out_value;
        o_m_axis_tuser[0] = r_out_err;
        o_m_axis_tlast    = r_out_last;
    end

`ifndef NO_ASSERTIONS
    a_reset_work: assert property (@(posedge i_clk) !i_rst_n |=> r_work == '0)
        else $error("working value not cleared by reset");

    a_out_tracks_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_value == r_work)
        else $error("result value differs from working value");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.req_type == bfs_pkg::REQ_LOAD)
        |=> !r_out_err && (r_out_value == $past(r_in.load_value)))
        else $error("load item did not replace the working value");

    a_error_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && unit_res.range_error |=> r_work == $past(r_work))
        else $error("out-of-range field changed the working value");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while both registers are full");
`endif

endmodule

`default_nettype wire
